>>> hdl/astar_pkg.sv
// constants, types and helpers for the a* shortest path block
// no dependencies; imported by astar_shortest_path
package astar_pkg;

    localparam int MAX_NODES   = 16;
    localparam int WEIGHT_BITS = 8;

    localparam int NODE_BITS  = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_BITS   = $clog2(MAX_NODES + 1);
    localparam int ADJ_DEPTH  = MAX_NODES * MAX_NODES;
    localparam int ADDR_BITS  = $clog2(ADJ_DEPTH);
    localparam int G_BITS     = $clog2(MAX_NODES * (2 ** WEIGHT_BITS)) + 1;
    localparam int H_BITS     = 14;
    localparam int F_BITS     = ((G_BITS > H_BITS) ? G_BITS : H_BITS) + 1;
    localparam int COST_BITS  = 12;
    localparam int SUM_BITS   = ((COST_BITS > WEIGHT_BITS) ? COST_BITS : WEIGHT_BITS) + 1;

    localparam logic [H_BITS-1:0]    NO_ROUTE = H_BITS'(9999);
    localparam logic [COST_BITS-1:0] COST_CAP = COST_BITS'(4095);

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    function automatic logic [ADDR_BITS-1:0] adj_addr(input logic [NODE_BITS-1:0] row,
                                                      input logic [NODE_BITS-1:0] col);
        return ADDR_BITS'(ADDR_BITS'(row) * ADDR_BITS'(MAX_NODES)) + ADDR_BITS'(col);
    endfunction

endpackage

>>> hdl/astar_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module astar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/astar_shortest_path.sv
// a* shortest path over a small weighted graph held in an adjacency ram
// depends on astar_pkg and astar_ram
// add writes both directions of an edge and clear empties the graph; a query runs a
// breadth-first search from the target node and then the a* expansion, both paced
// by the one-entry-per-cycle walk of the adjacency ram, then walks the path back
// and emits one result a cycle; reset (synchronous, active low) empties the graph; no result stall
module astar_shortest_path
    import astar_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic [1:0]           i_action,
    input  logic [3:0]           i_node_a,
    input  logic [3:0]           i_node_b,
    input  logic [7:0]           i_weight,
    output logic                 busy,
    output logic                 o_valid,
    output logic [3:0]           o_path_node,
    output logic [COST_BITS-1:0] o_total_cost,
    output logic                 o_reached,
    output logic                 o_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_ADD2, S_BFS_POP, S_BFS_SCAN, S_A_INIT, S_A_MIN,
        S_A_SEL, S_A_RELAX, S_PATH_INIT, S_PATH, S_EMIT
    } t_state;

    t_state r_state;

    logic [NODE_BITS-1:0]   r_a, r_b, r_row, r_best, r_node, r_pi;
    logic [WEIGHT_BITS-1:0] r_w;
    logic [CNT_BITS-1:0]    r_head, r_tail, r_i, r_cnt, r_e;
    logic [H_BITS-1:0]      r_hcur;
    logic                   r_pv, r_found, r_rvld, r_reached;
    logic [F_BITS-1:0]      r_bf;
    logic [G_BITS-1:0]      r_bg, r_gb;
    logic [COST_BITS-1:0]   r_total;

    logic [H_BITS-1:0]    r_h     [MAX_NODES];
    logic [NODE_BITS-1:0] r_q     [MAX_NODES];
    logic [G_BITS-1:0]    r_g     [MAX_NODES];
    logic [NODE_BITS-1:0] r_pred  [MAX_NODES];
    logic [NODE_BITS-1:0] r_chain [MAX_NODES];
    logic [MAX_NODES-1:0] r_known, r_pvld, r_vis;
    logic [ADJ_DEPTH-1:0] r_evld;

    logic                   r_o_valid, r_o_reached, r_o_last;
    logic [3:0]             r_o_node;
    logic [COST_BITS-1:0]   r_o_total;

    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_waddr, ram_raddr;
    logic [WEIGHT_BITS-1:0] ram_rdata;
    logic [NODE_BITS-1:0]   in_a, in_b, pi_idx, ri_idx;
    logic                   in_range, accept;
    logic [F_BITS-1:0]      n_f;
    logic                   n_better;
    logic [G_BITS-1:0]      n_t;
    logic [SUM_BITS-1:0]    n_sum;
    logic                   n_step;

    astar_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (ADJ_DEPTH)
    ) u_adj (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_state == S_ADD2 ? r_w : WEIGHT_BITS'(i_weight)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign in_a     = NODE_BITS'(i_node_a);
    assign in_b     = NODE_BITS'(i_node_b);
    assign in_range = (32'(i_node_a) < MAX_NODES) && (32'(i_node_b) < MAX_NODES);
    assign pi_idx   = r_pi;
    assign ri_idx   = r_i[NODE_BITS-1:0];
    assign n_step   = r_pvld[r_node] && (r_cnt < CNT_BITS'(MAX_NODES));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = adj_addr(in_a, in_b);
        ram_raddr = adj_addr(r_row, ri_idx);
        if (accept && t_action'(i_action) == ACT_ADD && in_range) begin
            ram_we = 1'b1;
        end
        if (r_state == S_ADD2) begin
            ram_we    = 1'b1;
            ram_waddr = adj_addr(r_b, r_a);
        end
        if (r_state == S_PATH) begin
            ram_raddr = adj_addr(r_pred[r_node], r_node);
        end
    end

    always_comb begin
        n_f      = F_BITS'(r_g[ri_idx]) + F_BITS'(r_h[ri_idx]);
        n_better = r_known[ri_idx] && !r_vis[ri_idx] &&
                   (!r_found || n_f < r_bf || (n_f == r_bf && r_g[ri_idx] < r_bg));
        n_t      = r_gb + G_BITS'(ram_rdata);
        n_sum    = SUM_BITS'(r_total) + SUM_BITS'(r_rvld ? ram_rdata : '0);
    end

    always_ff @(posedge i_clk) begin
        r_rvld <= r_evld[ram_raddr];
        r_pi   <= ri_idx;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_evld    <= '0;
            r_o_valid <= 1'b0;
            r_pv      <= 1'b0;
        end else begin
            r_o_valid <= (r_state == S_EMIT);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_a <= in_a;
                        r_b <= in_b;
                        r_w <= WEIGHT_BITS'(i_weight);
                        unique case (t_action'(i_action))
                            ACT_ADD: begin
                                if (in_range) begin
                                    r_evld[adj_addr(in_a, in_b)] <= 1'b1;
                                    r_state <= S_ADD2;
                                end
                            end
                            ACT_CLEAR: r_evld <= '0;
                            ACT_QUERY: begin
                                if (in_range) begin
                                    for (int k = 0; k < MAX_NODES; k++) begin
                                        r_h[k] <= (NODE_BITS'(k) == in_b) ? '0 : NO_ROUTE;
                                    end
                                    r_q[0]    <= in_b;
                                    r_head    <= '0;
                                    r_tail    <= CNT_BITS'(1);
                                    r_state   <= S_BFS_POP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_ADD2: begin
                    r_evld[adj_addr(r_b, r_a)] <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_BFS_POP: begin
                    if (r_head == r_tail) begin
                        r_state <= S_A_INIT;
                    end else begin
                        r_row   <= r_q[r_head[NODE_BITS-1:0]];
                        r_hcur  <= r_h[r_q[r_head[NODE_BITS-1:0]]];
                        r_head  <= r_head + 1'b1;
                        r_i     <= '0;
                        r_pv    <= 1'b0;
                        r_state <= S_BFS_SCAN;
                    end
                end
                S_BFS_SCAN: begin
                    r_pv <= (r_i < CNT_BITS'(MAX_NODES));
                    if (r_i < CNT_BITS'(MAX_NODES)) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_state <= S_BFS_POP;
                    end
                    if (r_pv && r_rvld && r_h[pi_idx] == NO_ROUTE &&
                        r_tail < CNT_BITS'(MAX_NODES)) begin
                        r_h[pi_idx]                <= r_hcur + 1'b1;
                        r_q[r_tail[NODE_BITS-1:0]] <= pi_idx;
                        r_tail                     <= r_tail + 1'b1;
                    end
                end
                S_A_INIT: begin
                    for (int k = 0; k < MAX_NODES; k++) begin
                        r_g[k] <= '0;
                    end
                    r_known      <= MAX_NODES'(1) << r_a;
                    r_pvld       <= '0;
                    r_vis        <= '0;
                    r_i          <= '0;
                    r_found      <= 1'b0;
                    r_state      <= S_A_MIN;
                end
                S_A_MIN: begin
                    if (n_better) begin
                        r_found <= 1'b1;
                        r_best  <= ri_idx;
                        r_bf    <= n_f;
                        r_bg    <= r_g[ri_idx];
                    end
                    if (r_i == CNT_BITS'(MAX_NODES - 1)) begin
                        r_state <= S_A_SEL;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_A_SEL: begin
                    if (!r_found) begin
                        r_state <= S_PATH_INIT;
                    end else begin
                        r_vis[r_best] <= 1'b1;
                        if (r_best == r_b) begin
                            r_state <= S_PATH_INIT;
                        end else begin
                            r_gb    <= r_g[r_best];
                            r_row   <= r_best;
                            r_i     <= '0;
                            r_pv    <= 1'b0;
                            r_state <= S_A_RELAX;
                        end
                    end
                end
                S_A_RELAX: begin
                    r_pv <= (r_i < CNT_BITS'(MAX_NODES));
                    if (r_i < CNT_BITS'(MAX_NODES)) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_i     <= '0;
                        r_found <= 1'b0;
                        r_state <= S_A_MIN;
                    end
                    if (r_pv && r_rvld && (!r_known[pi_idx] || n_t < r_g[pi_idx])) begin
                        r_known[pi_idx] <= 1'b1;
                        r_g[pi_idx]     <= n_t;
                        r_pred[pi_idx]  <= r_row;
                        r_pvld[pi_idx]  <= 1'b1;
                    end
                end
                S_PATH_INIT: begin
                    r_chain[0] <= r_b;
                    r_cnt      <= CNT_BITS'(1);
                    r_node     <= r_b;
                    r_total    <= '0;
                    r_pv       <= 1'b0;
                    r_reached  <= r_pvld[r_b] || (r_a == r_b);
                    r_state    <= S_PATH;
                end
                S_PATH: begin
                    if (r_pv) begin
                        r_total <= (n_sum > SUM_BITS'(COST_CAP)) ? COST_CAP
                                                                 : COST_BITS'(n_sum);
                    end
                    if (n_step) begin
                        r_node                      <= r_pred[r_node];
                        r_chain[r_cnt[NODE_BITS-1:0]] <= r_pred[r_node];
                        r_cnt                       <= r_cnt + 1'b1;
                        r_pv                        <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_e     <= r_cnt - 1'b1;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    r_o_node    <= 4'(r_chain[r_e[NODE_BITS-1:0]]);
                    r_o_total   <= r_total;
                    r_o_reached <= r_reached;
                    r_o_last    <= (r_e == '0);
                    if (r_e == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_e <= r_e - 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_o_valid;
    assign o_path_node  = r_o_node;
    assign o_total_cost = r_o_total;
    assign o_reached    = r_o_reached;
    assign o_last       = r_o_last;

endmodule
